FILE: rtl/hcp_pkg.sv
// shared widths, types and constants for the hermite curve point unit
package hcp_pkg;

  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 16;
  localparam int T_BITS     = FRAC_BITS + 1;
  localparam int OUT_BITS   = COORD_BITS + 2;

  // coefficient widths: ca = 2p0-2p1+m0+m1, cb = -3p0+3p1-2m0-m1
  localparam int CA_W = COORD_BITS + 3;
  localparam int CB_W = COORD_BITS + 4;

  // horner accumulator widths, one multiply by signed t per step
  localparam int TS_W  = T_BITS + 1;
  localparam int A1_W  = CA_W + TS_W;
  localparam int A2_W  = A1_W + TS_W;
  localparam int A3_W  = A2_W + TS_W;
  localparam int LO_W  = A2_W / 2;
  localparam int HI_W  = A2_W - LO_W;
  localparam int PLO_W = LO_W + T_BITS;
  localparam int PHI_W = HI_W + TS_W;
  localparam int INT_W = A3_W - 3 * FRAC_BITS;

  localparam int LANE_STAGES = 6;

  localparam logic signed [INT_W:0] SAT_HI = (INT_W + 1)'(2 ** (OUT_BITS - 1) - 1);
  localparam logic signed [INT_W:0] SAT_LO = -(INT_W + 1)'(2 ** (OUT_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [T_BITS-1:0]     tparam_t;
  typedef logic signed [OUT_BITS-1:0]   point_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } hcp_ctrl_t;

endpackage

FILE: rtl/hcp_curve_if.sv
// request channel carrying the control points, tangents and curve parameter
interface hcp_curve_if import hcp_pkg::*; ();

  logic    valid;
  logic    ready;
  coord_t  start_x;
  coord_t  start_y;
  coord_t  end_x;
  coord_t  end_y;
  coord_t  tangent_start_x;
  coord_t  tangent_start_y;
  coord_t  tangent_end_x;
  coord_t  tangent_end_y;
  tparam_t param_t;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
    output tangent_start_x, tangent_start_y, tangent_end_x, tangent_end_y, param_t,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
    input  tangent_start_x, tangent_start_y, tangent_end_x, tangent_end_y, param_t,
    output ready
  );

endinterface

FILE: rtl/hcp_point_if.sv
// result channel carrying one evaluated curve point
interface hcp_point_if import hcp_pkg::*; ();

  logic   valid;
  logic   ready;
  point_t point_x;
  point_t point_y;

  modport source (
    output valid, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y,
    output ready
  );

endinterface

FILE: rtl/hcp_lane.sv
// one axis of the hermite evaluation: horner pipeline, truncation and saturation
module hcp_lane import hcp_pkg::*; (
  input  logic      clk,
  input  hcp_ctrl_t ctrl,
  input  coord_t    p0,
  input  coord_t    p1,
  input  coord_t    m0,
  input  coord_t    m1,
  input  tparam_t   t,
  output point_t    result
);

  // stage 0: coefficients
  logic signed [CA_W-1:0] ca;
  logic signed [CB_W-1:0] cb;
  coord_t                 p0_s0;
  coord_t                 m0_s0;
  tparam_t                t_s0;

  // stage 1: ca*t + cb
  logic signed [A1_W-1:0] acc1;
  coord_t                 p0_s1;
  coord_t                 m0_s1;
  tparam_t                t_s1;

  // stage 2: acc1*t + m0
  logic signed [A2_W-1:0] acc2;
  coord_t                 p0_s2;
  tparam_t                t_s2;

  // stage 3: split partial products of acc2*t
  logic        [PLO_W-1:0] pp_lo;
  logic signed [PHI_W-1:0] pp_hi;
  coord_t                  p0_s3;

  // stage 4: full sum
  logic signed [A3_W-1:0] acc3;

  // stage 5: truncated, saturated point
  point_t res;

  logic signed [CA_W-1:0]  ca_next;
  logic signed [CB_W-1:0]  cb_next;
  logic signed [TS_W-1:0]  ts_s0;
  logic signed [TS_W-1:0]  ts_s1;
  logic signed [TS_W-1:0]  ts_s2;
  logic signed [A1_W-1:0]  acc1_next;
  logic signed [A2_W-1:0]  acc2_next;
  logic        [LO_W-1:0]  acc2_lo;
  logic signed [HI_W-1:0]  acc2_hi;
  logic signed [A3_W-1:0]  acc3_next;
  logic signed [INT_W-1:0] q;
  logic                    frac_nz;
  logic signed [INT_W:0]   tr;
  point_t                  res_next;

  always_comb begin
    ca_next = (CA_W'(p0) <<< 1) - (CA_W'(p1) <<< 1) + CA_W'(m0) + CA_W'(m1);
    cb_next = (CB_W'(p1) <<< 1) + CB_W'(p1) - (CB_W'(p0) <<< 1) - CB_W'(p0)
            - (CB_W'(m0) <<< 1) - CB_W'(m1);
  end

  assign ts_s0 = $signed({1'b0, t_s0});
  assign ts_s1 = $signed({1'b0, t_s1});
  assign ts_s2 = $signed({1'b0, t_s2});

  assign acc1_next = A1_W'(ca) * A1_W'(ts_s0) + (A1_W'(cb) <<< FRAC_BITS);
  assign acc2_next = A2_W'(acc1) * A2_W'(ts_s1) + (A2_W'(m0_s1) <<< (2 * FRAC_BITS));

  assign acc2_lo = acc2[LO_W-1:0];
  assign acc2_hi = acc2[A2_W-1:LO_W];

  assign acc3_next = (A3_W'(pp_hi) <<< LO_W) + A3_W'($signed({1'b0, pp_lo}))
                   + (A3_W'(p0_s3) <<< (3 * FRAC_BITS));

  always_comb begin
    q       = acc3[A3_W-1:3*FRAC_BITS];
    frac_nz = |acc3[3*FRAC_BITS-1:0];
    tr      = (INT_W + 1)'(q) + (INT_W + 1)'($signed({1'b0, q[INT_W-1] & frac_nz}));
    if (tr > SAT_HI) begin
      res_next = OUT_BITS'(SAT_HI);
    end else if (tr < SAT_LO) begin
      res_next = OUT_BITS'(SAT_LO);
    end else begin
      res_next = OUT_BITS'(tr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      ca    <= ca_next;
      cb    <= cb_next;
      p0_s0 <= p0;
      m0_s0 <= m0;
      t_s0  <= t;
    end
    if (ctrl.load[1]) begin
      acc1  <= acc1_next;
      p0_s1 <= p0_s0;
      m0_s1 <= m0_s0;
      t_s1  <= t_s0;
    end
    if (ctrl.load[2]) begin
      acc2  <= acc2_next;
      p0_s2 <= p0_s1;
      t_s2  <= t_s1;
    end
    if (ctrl.load[3]) begin
      pp_lo <= PLO_W'(acc2_lo) * PLO_W'(t_s2);
      pp_hi <= PHI_W'(acc2_hi) * PHI_W'(ts_s2);
      p0_s3 <= p0_s2;
    end
    if (ctrl.load[4]) begin
      acc3 <= acc3_next;
    end
    if (ctrl.load[5]) begin
      res <= res_next;
    end
  end

  assign result = res;

endmodule

FILE: rtl/hcp_merge.sv
// joins the x and y lane results into one point and holds it for the receiver
module hcp_merge import hcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               lane_valid,
  input  point_t             lane_x,
  input  point_t             lane_y,
  output logic               load,
  hcp_point_if.source        point
);

  logic   out_valid;
  point_t out_x;
  point_t out_y;

  assign load = !out_valid || point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && lane_valid) begin
      out_x <= lane_x;
      out_y <= lane_y;
    end
  end

  assign point.valid   = out_valid;
  assign point.point_x = out_x;
  assign point.point_y = out_y;

endmodule

FILE: rtl/hermite_curve_point_unit.sv
// top level of the 2d cubic hermite curve point unit
//
// each request on the curve channel carries start and end points, start and
// end tangents and a parameter t (unsigned, 16 fraction bits, 65536 = 1.0).
// the point channel returns the curve point h(t), x and y truncated toward
// zero and saturated to 13 bits signed.
// the x and y axes run in two identical lanes, each a six-stage horner
// pipeline (coefficients, three multiply-by-t steps with the widest split into
// two partial products, final sum, truncate and saturate); an output register
// joins both lanes.
// a result passes through the lane stages and then the output register before it is valid.
// throughput: one point per cycle while the receiver does not stall, set by the fully pipelined lanes.
// reset clears all stage valid flags and the output valid; requests in flight
// at reset are dropped.
// when the receiver stalls, the point is held, stages behind it fill up
// and requests are still taken until every stage holds a point; then ready
// drops until the receiver takes the held point.
module hermite_curve_point_unit import hcp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  hcp_curve_if.sink    curve,
  hcp_point_if.source  point
);

  logic [LANE_STAGES-1:0] stage_valid;
  logic [LANE_STAGES-1:0] stage_valid_next;
  hcp_ctrl_t              ctrl;
  logic                   merge_load;
  point_t                 lane_x;
  point_t                 lane_y;

  always_comb begin
    logic ld_up;
    ld_up = merge_load;
    for (int i = LANE_STAGES - 1; i >= 0; i--) begin
      ctrl.load[i] = !stage_valid[i] || ld_up;
      ld_up        = ctrl.load[i];
    end
  end

  always_comb begin
    stage_valid_next[0] = ctrl.load[0] ? curve.valid : stage_valid[0];
    for (int i = 1; i < LANE_STAGES; i++) begin
      stage_valid_next[i] = ctrl.load[i] ? stage_valid[i-1] : stage_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign curve.ready = ctrl.load[0];

  hcp_lane u_lane_x (
    .clk    (clk),
    .ctrl   (ctrl),
    .p0     (curve.start_x),
    .p1     (curve.end_x),
    .m0     (curve.tangent_start_x),
    .m1     (curve.tangent_end_x),
    .t      (curve.param_t),
    .result (lane_x)
  );

  hcp_lane u_lane_y (
    .clk    (clk),
    .ctrl   (ctrl),
    .p0     (curve.start_y),
    .p1     (curve.end_y),
    .m0     (curve.tangent_start_y),
    .m1     (curve.tangent_end_y),
    .t      (curve.param_t),
    .result (lane_y)
  );

  hcp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (stage_valid[LANE_STAGES-1]),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .load       (merge_load),
    .point      (point)
  );

endmodule

FILE: verif/testbench.sv
// testbench for the hermite curve point unit: randomized curve requests checked against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = LANE_STAGES + 6;
  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1 << FRAC_BITS);
  localparam logic [T_BITS-1:0] T_MAX = '1;
  localparam coord_t C_MAX = coord_t'(2 ** (COORD_BITS - 1) - 1);
  localparam coord_t C_MIN = coord_t'(-(2 ** (COORD_BITS - 1)));

  typedef struct {
    coord_t start_x, start_y, end_x, end_y;
    coord_t tangent_start_x, tangent_start_y, tangent_end_x, tangent_end_y;
    logic [T_BITS-1:0] t;
  } curve_req_t;

  typedef struct {
    point_t x;
    point_t y;
  } curve_point_t;

  logic clk;
  logic rst;

  hcp_curve_if curve_bus ();
  hcp_point_if point_bus ();

  hermite_curve_point_unit uut (
    .clk   (clk),
    .rst   (rst),
    .curve (curve_bus.sink),
    .point (point_bus.source)
  );

  curve_point_t expected_points[$];
  int mismatch_count;
  int requests_sent;
  int points_checked;
  int above_one_count;
  int idle_cycles;
  bit sender_idling;
  bit receiver_idling;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic point_t hermite_axis(input coord_t p0, input coord_t p1,
                                          input coord_t m0, input coord_t m1,
                                          input logic [T_BITS-1:0] t);
    logic signed [95:0] wp0, wp1, wm0, wm1, tw, ca, cb, acc, mag;
    logic signed [95:0] lim;
    wp0 = p0;
    wp1 = p1;
    wm0 = m0;
    wm1 = m1;
    tw  = {{(96 - T_BITS){1'b0}}, t};
    lim = 96'sd1 <<< (OUT_BITS - 1);
    ca  = 2 * wp0 - 2 * wp1 + wm0 + wm1;
    cb  = -3 * wp0 + 3 * wp1 - 2 * wm0 - wm1;
    acc = ca * tw + (cb <<< FRAC_BITS);
    acc = acc * tw + (wm0 <<< (2 * FRAC_BITS));
    acc = acc * tw + (wp0 <<< (3 * FRAC_BITS));
    // truncate toward zero on the magnitude, then saturate
    mag = (acc < 0) ? -acc : acc;
    mag = mag >>> (3 * FRAC_BITS);
    if (acc < 0)
      return (mag > lim) ? point_t'(-lim) : point_t'(-mag);
    return (mag > lim - 1) ? point_t'(lim - 1) : point_t'(mag);
  endfunction

  function automatic curve_point_t hermite_point(input curve_req_t r);
    curve_point_t p;
    p.x = hermite_axis(r.start_x, r.end_x, r.tangent_start_x, r.tangent_end_x, r.t);
    p.y = hermite_axis(r.start_y, r.end_y, r.tangent_start_y, r.tangent_end_y, r.t);
    return p;
  endfunction

  function automatic curve_req_t make_request(input coord_t sx, input coord_t sy,
                                              input coord_t ex, input coord_t ey,
                                              input coord_t tsx, input coord_t tsy,
                                              input coord_t tex, input coord_t tey,
                                              input logic [T_BITS-1:0] t);
    curve_req_t r;
    r.start_x = sx;
    r.start_y = sy;
    r.end_x = ex;
    r.end_y = ey;
    r.tangent_start_x = tsx;
    r.tangent_start_y = tsy;
    r.tangent_end_x = tex;
    r.tangent_end_y = tey;
    r.t = t;
    return r;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(0, 7)) - 3);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [T_BITS-1:0] random_param();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12)
      return T_BITS'($urandom_range(0, T_ONE));
    else if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return T_BITS'(1);
        2: return T_ONE - T_BITS'(1);
        default: return T_ONE;
      endcase
    end else if (pick < 18)
      return T_BITS'($urandom_range(T_ONE + 1, T_MAX));
    return T_BITS'($urandom);
  endfunction

  function automatic curve_req_t random_request();
    return make_request(random_coord(), random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), random_coord(), random_coord(),
                        random_param());
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_request(input curve_req_t r);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      curve_bus.valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    curve_bus.start_x = r.start_x;
    curve_bus.start_y = r.start_y;
    curve_bus.end_x = r.end_x;
    curve_bus.end_y = r.end_y;
    curve_bus.tangent_start_x = r.tangent_start_x;
    curve_bus.tangent_start_y = r.tangent_start_y;
    curve_bus.tangent_end_x = r.tangent_end_x;
    curve_bus.tangent_end_y = r.tangent_end_y;
    curve_bus.param_t = r.t;
    curve_bus.valid = 1'b1;
    @(posedge clk);
    while (!curve_bus.ready) @(posedge clk);
    expected_points.push_back(hermite_point(r));
    requests_sent++;
    if (r.t > T_ONE) above_one_count++;
  endtask

  task automatic release_request();
    @(negedge clk);
    curve_bus.valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
    send_request(make_request(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_ONE));
    send_request(make_request(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
                              T_ONE >> 1));
    send_request(make_request(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                              T_ONE >> 1));
    send_request(make_request(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1));
    send_request(make_request(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                              T_ONE - 1));
    // fractional results on both sides of zero
    send_request(make_request(-1, 1, 0, 0, 0, 0, 0, 0, T_ONE >> 1));
    send_request(make_request(0, 0, -1, 1, 0, 0, 0, 0, T_ONE >> 2));
    send_request(make_request(0, 0, 0, 0, -1, 1, 1, -1, 3 * (T_ONE >> 2)));
    send_request(make_request(5, -5, -7, 7, 3, -3, -2, 2, 12345));
    // parameter above one, saturating high and low
    send_request(make_request(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, T_MAX));
    send_request(make_request(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, T_MAX));
    send_request(make_request(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_MAX));
    send_request(make_request(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_MAX));
    send_request(make_request(10, -10, 20, -20, 0, 0, 0, 0, T_ONE + 1));
    send_request(make_request(100, -100, 300, -300, C_MAX, C_MIN, C_MAX, C_MIN,
                              T_ONE + (T_ONE >> 1)));
    send_request(make_request(0, 0, 0, 0, 0, 0, C_MAX, C_MIN, T_MAX - 1));
    send_request(make_request(C_MAX, C_MIN, 0, 0, 0, 0, 0, 0, T_ONE + (T_ONE >> 2)));
    release_request();
  endtask

  task automatic test_pause_until_drained();
    wait_for_drain();
    repeat (3) send_request(random_request());
    release_request();
    wait_for_drain();
  endtask

  task automatic test_random_curves(input int count);
    repeat (count) send_request(random_request());
    release_request();
  endtask

  task automatic test_back_to_back(input int count);
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    repeat (count) send_request(random_request());
    release_request();
  endtask

  initial begin
    rst = 1'b1;
    curve_bus.valid = 1'b0;
    curve_bus.start_x = '0;
    curve_bus.start_y = '0;
    curve_bus.end_x = '0;
    curve_bus.end_y = '0;
    curve_bus.tangent_start_x = '0;
    curve_bus.tangent_start_y = '0;
    curve_bus.tangent_end_x = '0;
    curve_bus.tangent_end_y = '0;
    curve_bus.param_t = '0;
    mismatch_count = 0;
    requests_sent = 0;
    points_checked = 0;
    above_one_count = 0;
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_pause_until_drained();
    test_random_curves(340);
    test_back_to_back(60);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d points never returned", expected_points.size()));
    $display("sent %0d curve requests (%0d with t above one), checked %0d points",
             requests_sent, above_one_count, points_checked);
    $display("extremes, truncation, saturation, both-side stalls and full rate were covered");
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    point_bus.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (receiver_idling && $urandom_range(0, 2) == 0) begin
        point_bus.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        point_bus.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    curve_point_t want;
    if (!rst && point_bus.valid && point_bus.ready) begin
      points_checked++;
      if (expected_points.size() == 0)
        report_mismatch($sformatf("unexpected point (%0d, %0d)",
                                  point_bus.point_x, point_bus.point_y));
      else begin
        want = expected_points.pop_front();
        if (point_bus.point_x !== want.x)
          report_mismatch($sformatf("point_x %0d, expected %0d", point_bus.point_x, want.x));
        if (point_bus.point_y !== want.y)
          report_mismatch($sformatf("point_y %0d, expected %0d", point_bus.point_y, want.y));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (curve_bus.valid && curve_bus.ready) || (point_bus.valid && point_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no request or point accepted", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

endmodule

FILE: filelist.f
rtl/hcp_pkg.sv
rtl/hcp_curve_if.sv
rtl/hcp_point_if.sv
rtl/hcp_lane.sv
rtl/hcp_merge.sv
rtl/hermite_curve_point_unit.sv
verif/testbench.sv
